// ===== sv/artq_pkg.sv =====
// ----------------------------------------------------------------------------
// artq_pkg
// Shared types, sizes and codes of the ACK/retry transmit queue.
// ----------------------------------------------------------------------------
package artq_pkg;

    // Ring and channel sizes.
    localparam int SLOT_COUNT    = 8;
    localparam int CHANNEL_COUNT = 4;
    localparam int SLOT_W        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W         = $clog2(SLOT_COUNT + 1);
    localparam int CH_W          = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    // Slot phases.
    localparam logic [1:0] PH_FREE   = 2'd0;
    localparam logic [1:0] PH_QUEUED = 2'd1;
    localparam logic [1:0] PH_WAIT   = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_PUSHED    = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_BAD_CHAN  = 3'd2;
    localparam logic [2:0] ST_SEND_NEW  = 3'd3;
    localparam logic [2:0] ST_SEND_RTRY = 3'd4;
    localparam logic [2:0] ST_EXHAUSTED = 3'd5;
    localparam logic [2:0] ST_IDLE      = 3'd6;

    // Request type codes.
    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_SCHED = 1'b1;

    // Register indexes of the configuration port.
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_MAX_RTY = 1'b1;

    // One transmit slot.
    typedef struct packed {
        logic [1:0]  phase;
        logic [3:0]  chan;
        logic [7:0]  seq;
        logic [47:0] deadline;
        logic [7:0]  retry;
        logic        ack_wanted;
    } t_slot;

    // Write request into the slot store.
    typedef struct packed {
        logic              we_all;
        logic              we_phase;
        logic              we_deadline;
        logic              we_retry;
        logic [SLOT_W-1:0] addr;
        t_slot             data;
    } t_slot_wr;

    // Flags from the shared compare unit for the addressed slot.
    typedef struct packed {
        logic        is_free;
        logic        is_queued;
        logic        ack_hit;
        logic        due;
        logic        exhausted;
        logic [47:0] new_deadline;
    } t_eval;

    // Ring pointer increment with wrap.
    function automatic logic [SLOT_W-1:0] ptr_inc(input logic [SLOT_W-1:0] p);
        logic [SLOT_W-1:0] r;
        if (p == SLOT_W'(SLOT_COUNT - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // Slot number as reported on the result, masked to three bits.
    function automatic logic [2:0] slot_out(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+2:0] w;
        w = {3'b000, idx};
        return w[2:0];
    endfunction

endpackage

// ===== sv/artq_slot_store.sv =====
// ----------------------------------------------------------------------------
// artq_slot_store
// Register file of transmit slots with one write port and one read port.
// ----------------------------------------------------------------------------
module artq_slot_store
    import artq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_slot_wr          i_wr,
    input  logic [SLOT_W-1:0] i_rd_addr,
    output t_slot             o_rd
);

    logic [1:0]  r_phase    [SLOT_COUNT];
    logic [3:0]  r_chan     [SLOT_COUNT];
    logic [7:0]  r_seq      [SLOT_COUNT];
    logic [47:0] r_deadline [SLOT_COUNT];
    logic [7:0]  r_retry    [SLOT_COUNT];
    logic        r_ackw     [SLOT_COUNT];

    // Phases reset to free; every other field is written before it is used.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_phase[k] <= PH_FREE;
            end
        end else if (i_wr.we_all || i_wr.we_phase) begin
            r_phase[i_wr.addr] <= i_wr.data.phase;
        end
    end

    // Payload fields of the slots.
    always_ff @(posedge i_clk) begin
        if (i_wr.we_all) begin
            r_chan[i_wr.addr] <= i_wr.data.chan;
            r_seq[i_wr.addr]  <= i_wr.data.seq;
            r_ackw[i_wr.addr] <= i_wr.data.ack_wanted;
        end
        if (i_wr.we_all || i_wr.we_deadline) begin
            r_deadline[i_wr.addr] <= i_wr.data.deadline;
        end
        if (i_wr.we_all || i_wr.we_retry) begin
            r_retry[i_wr.addr] <= i_wr.data.retry;
        end
    end

    // Read of the slot the sequencer points at.
    always_comb begin
        o_rd.phase      = r_phase[i_rd_addr];
        o_rd.chan       = r_chan[i_rd_addr];
        o_rd.seq        = r_seq[i_rd_addr];
        o_rd.deadline   = r_deadline[i_rd_addr];
        o_rd.retry      = r_retry[i_rd_addr];
        o_rd.ack_wanted = r_ackw[i_rd_addr];
    end

endmodule

// ===== sv/artq_slot_eval.sv =====
// ----------------------------------------------------------------------------
// artq_slot_eval
// Shared compare and add unit applied to one slot per cycle.
// ----------------------------------------------------------------------------
module artq_slot_eval
    import artq_pkg::*;
(
    input  t_slot       i_slot,
    input  logic [47:0] i_now_ms,
    input  logic [3:0]  i_rx_channel,
    input  logic [7:0]  i_rx_ack_seq,
    input  logic [15:0] i_retry_timeout_ms,
    input  logic [7:0]  i_max_retries,
    output t_eval       o_eval
);

    logic is_wait;

    // Phase decode, reply match, deadline check and the new deadline.
    always_comb begin
        is_wait                = (i_slot.phase == PH_WAIT);
        o_eval.is_free         = (i_slot.phase == PH_FREE);
        o_eval.is_queued       = (i_slot.phase == PH_QUEUED);
        o_eval.ack_hit         = is_wait && (i_slot.chan == i_rx_channel)
                                 && (i_slot.seq == i_rx_ack_seq);
        o_eval.due             = is_wait && (i_now_ms >= i_slot.deadline);
        o_eval.exhausted       = (i_slot.retry >= i_max_retries);
        o_eval.new_deadline    = i_now_ms + {32'd0, i_retry_timeout_ms};
    end

endmodule

// ===== sv/artq_ctrl.sv =====
// ----------------------------------------------------------------------------
// artq_ctrl
// Sequencer that serves push commands and walks the slot ring for schedule commands.
// ----------------------------------------------------------------------------
module artq_ctrl
    import artq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [47:0] i_now_ms,
    input  logic [3:0]  i_tx_channel,
    input  logic        i_tx_wants_ack,
    input  logic        i_rx_valid,
    input  logic        i_rx_is_ack,
    input  logic        i_rx_is_nak,
    input  logic [3:0]  i_rx_channel,
    input  logic [7:0]  i_rx_ack_seq,
    input  logic [15:0] i_retry_timeout_ms,
    input  logic [7:0]  i_max_retries,
    output logic        o_result_valid,
    output logic [2:0]  o_status,
    output logic [2:0]  o_slot_index,
    output logic [3:0]  o_out_channel,
    output logic [7:0]  o_out_seq
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PUSH  = 3'd1;
    localparam logic [2:0] S_ACK   = 3'd2;
    localparam logic [2:0] S_DROP  = 3'd3;
    localparam logic [2:0] S_QSCAN = 3'd4;
    localparam logic [2:0] S_DSCAN = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SLOT_W-1:0] r_ptr, n_ptr;
    logic [SLOT_W-1:0] r_step, n_step;
    logic              r_drop_fin, n_drop_fin;
    logic [7:0]        r_chan_seq [CHANNEL_COUNT];
    logic              seq_inc;

    logic              r_strobe, n_strobe;
    logic [2:0]        r_status, n_status;
    logic [2:0]        r_slot, n_slot;
    logic [3:0]        r_ochan, n_ochan;
    logic [7:0]        r_oseq, n_oseq;

    // Latched command beat.
    logic [47:0]       r_now;
    logic [3:0]        r_tx_ch;
    logic              r_tx_ackw;
    logic              r_nak;
    logic [3:0]        r_rx_ch;
    logic [7:0]        r_rx_seq;

    t_slot_wr          wr;
    logic [SLOT_W-1:0] rd_addr;
    t_slot             rd_slot;
    t_eval             ev;
    logic              rx_apply;
    logic              tx_ch_ok;
    logic              last_step;
    logic [7:0]        push_seq;

    artq_slot_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd      (rd_slot)
    );

    artq_slot_eval u_eval (
        .i_slot             (rd_slot),
        .i_now_ms           (r_now),
        .i_rx_channel       (r_rx_ch),
        .i_rx_ack_seq       (r_rx_seq),
        .i_retry_timeout_ms (i_retry_timeout_ms),
        .i_max_retries      (i_max_retries),
        .o_eval             (ev)
    );

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_strobe;
    assign o_status       = r_status;
    assign o_slot_index   = r_slot;
    assign o_out_channel  = r_ochan;
    assign o_out_seq      = r_oseq;

    // Drops read the head slot; every other pass reads at the scan pointer.
    assign rd_addr   = (r_state == S_DROP) ? r_head : r_ptr;
    assign last_step = (r_step == SLOT_W'(SLOT_COUNT - 1));
    assign rx_apply  = i_rx_valid && ({1'b0, i_rx_channel} < 5'(CHANNEL_COUNT))
                       && (i_rx_is_ack || i_rx_is_nak);
    assign tx_ch_ok  = ({1'b0, r_tx_ch} < 5'(CHANNEL_COUNT));
    assign push_seq  = r_chan_seq[r_tx_ch[CH_W-1:0]];

    // Next-state logic of the sequencer.
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_step     = r_step;
        n_drop_fin = r_drop_fin;
        n_strobe   = 1'b0;
        n_status   = r_status;
        n_slot     = r_slot;
        n_ochan    = r_ochan;
        n_oseq     = r_oseq;
        seq_inc    = 1'b0;
        wr         = '0;
        wr.addr    = r_ptr;
        wr.data    = rd_slot;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_step = '0;
                    if (i_req_type == REQ_PUSH) begin
                        n_state = S_PUSH;
                    end else if (rx_apply) begin
                        n_state = S_ACK;
                        n_ptr   = '0;
                    end else begin
                        n_state = S_QSCAN;
                        n_ptr   = r_head;
                    end
                end
            end

            S_PUSH: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                n_slot   = '0;
                n_ochan  = '0;
                n_oseq   = '0;
                if (r_count >= CNT_W'(SLOT_COUNT)) begin
                    n_status = ST_FULL;
                end else if (!tx_ch_ok) begin
                    n_status = ST_BAD_CHAN;
                end else begin
                    wr.we_all           = 1'b1;
                    wr.addr             = r_tail;
                    wr.data.phase       = PH_QUEUED;
                    wr.data.chan        = r_tx_ch;
                    wr.data.seq         = push_seq;
                    wr.data.deadline    = ev.new_deadline;
                    wr.data.retry       = '0;
                    wr.data.ack_wanted  = r_tx_ackw;
                    seq_inc             = 1'b1;
                    n_tail              = ptr_inc(r_tail);
                    n_count             = r_count + 1'b1;
                    n_status            = ST_PUSHED;
                    n_slot              = slot_out(r_tail);
                    n_ochan             = r_tx_ch;
                    n_oseq              = push_seq;
                end
            end

            // Lowest-indexed waiting slot that matches the reply is freed on an ACK, or made due at once on a NAK.
            S_ACK: begin
                if (ev.ack_hit) begin
                    if (r_nak) begin
                        wr.we_deadline   = 1'b1;
                        wr.data.deadline = r_now;
                    end else begin
                        wr.we_phase   = 1'b1;
                        wr.data.phase = PH_FREE;
                    end
                end
                if (ev.ack_hit || last_step) begin
                    n_state    = S_DROP;
                    n_drop_fin = 1'b0;
                end else begin
                    n_ptr  = ptr_inc(r_ptr);
                    n_step = r_step + 1'b1;
                end
            end

            // Retire free slots at the head of the ring, one per cycle.
            S_DROP: begin
                if ((r_count != '0) && ev.is_free) begin
                    n_head  = ptr_inc(r_head);
                    n_count = r_count - 1'b1;
                end else if (r_drop_fin) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                end else begin
                    n_state = S_QSCAN;
                    n_ptr   = r_head;
                    n_step  = '0;
                end
            end

            // Oldest queued slot is sent as a new frame.
            S_QSCAN: begin
                if (ev.is_queued) begin
                    n_status = ST_SEND_NEW;
                    n_slot   = slot_out(r_ptr);
                    n_ochan  = rd_slot.chan;
                    n_oseq   = rd_slot.seq;
                    wr.we_phase = 1'b1;
                    if (rd_slot.ack_wanted) begin
                        wr.data.phase    = PH_WAIT;
                        wr.we_deadline   = 1'b1;
                        wr.data.deadline = ev.new_deadline;
                        n_state          = S_IDLE;
                        n_strobe         = 1'b1;
                    end else begin
                        wr.data.phase = PH_FREE;
                        n_state       = S_DROP;
                        n_drop_fin    = 1'b1;
                    end
                end else if (last_step) begin
                    n_state = S_DSCAN;
                    n_ptr   = r_head;
                    n_step  = '0;
                end else begin
                    n_ptr  = ptr_inc(r_ptr);
                    n_step = r_step + 1'b1;
                end
            end

            // First waiting slot past its deadline is retried or exhausted.
            S_DSCAN: begin
                if (ev.due) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_slot   = slot_out(r_ptr);
                    n_ochan  = rd_slot.chan;
                    n_oseq   = rd_slot.seq;
                    if (ev.exhausted) begin
                        n_status = ST_EXHAUSTED;
                    end else begin
                        n_status         = ST_SEND_RTRY;
                        wr.we_retry      = 1'b1;
                        wr.data.retry    = rd_slot.retry + 1'b1;
                        wr.we_deadline   = 1'b1;
                        wr.data.deadline = ev.new_deadline;
                    end
                end else if (last_step) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_status = ST_IDLE;
                    n_slot   = '0;
                    n_ochan  = '0;
                    n_oseq   = '0;
                end else begin
                    n_ptr  = ptr_inc(r_ptr);
                    n_step = r_step + 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_strobe   <= 1'b0;
            r_drop_fin <= 1'b0;
            for (int k = 0; k < CHANNEL_COUNT; k++) begin
                r_chan_seq[k] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_strobe   <= n_strobe;
            r_drop_fin <= n_drop_fin;
            if (seq_inc) begin
                r_chan_seq[r_tx_ch[CH_W-1:0]] <= push_seq + 1'b1;
            end
        end
    end

    // Scan position and result payload.
    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_step   <= n_step;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_ochan  <= n_ochan;
        r_oseq   <= n_oseq;
    end

    // Command beat is captured when it is accepted.
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_now     <= i_now_ms;
            r_tx_ch   <= i_tx_channel;
            r_tx_ackw <= i_tx_wants_ack;
            r_nak     <= i_rx_is_nak;
            r_rx_ch   <= i_rx_channel;
            r_rx_seq  <= i_rx_ack_seq;
        end
    end

endmodule

// ===== sv/ack_retry_tx_queue_top.sv =====
// ----------------------------------------------------------------------------
// ack_retry_tx_queue_top
// Retransmission queue of an ARQ link with an APB-style register port.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. A push beat
// queues a frame in the tail slot with the channel's next sequence number;
// a schedule beat applies an optional received ACK or NAK and then picks
// the oldest queued slot, else the first overdue waiting slot.
// Each command gives one result beat, shown for exactly one cycle with
// o_result_valid high; the receiver cannot stall, so results never wait.
// A push goes from the idle state through the push state to its result beat.
// A schedule beat walks the ring one slot per cycle through the shared
// compare unit: a reply match pass when a reply applies, retiring freed
// head slots, the queued pass and, if it finds nothing, the deadline pass,
// then the result beat; a queued frame that wants no ACK frees its slot and
// the freed head slots are retired again before the result beat.
// busy stays high for the whole command; the next beat may be taken in the
// cycle its result is shown.
// Reset empties the ring, clears the channel sequence numbers and loads
// retry_timeout_ms = 100 and max_retries = 3; no clearing pass is needed.
// Registers: retry_timeout_ms at 0x0, max_retries at 0x4.
// ----------------------------------------------------------------------------
module ack_retry_tx_queue_top
    import artq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [47:0] i_now_ms,
    input  logic [3:0]  i_tx_channel,
    input  logic        i_tx_wants_ack,
    input  logic        i_rx_valid,
    input  logic        i_rx_is_ack,
    input  logic        i_rx_is_nak,
    input  logic [3:0]  i_rx_channel,
    input  logic [7:0]  i_rx_ack_seq,
    output logic        o_result_valid,
    output logic [2:0]  o_status,
    output logic [2:0]  o_slot_index,
    output logic [3:0]  o_out_channel,
    output logic [7:0]  o_out_seq
);

    logic [15:0] r_retry_timeout_ms;
    logic [7:0]  r_max_retries;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_timeout_ms <= 16'd100;
            r_max_retries      <= 8'd3;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_TIMEOUT) begin
                r_retry_timeout_ms <= pwdata[15:0];
            end else begin
                r_max_retries <= pwdata[7:0];
            end
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[2])
            REG_TIMEOUT: prdata = {16'd0, r_retry_timeout_ms};
            REG_MAX_RTY: prdata = {24'd0, r_max_retries};
            default:     prdata = '0;
        endcase
    end

    artq_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_req_type         (i_req_type),
        .i_now_ms           (i_now_ms),
        .i_tx_channel       (i_tx_channel),
        .i_tx_wants_ack     (i_tx_wants_ack),
        .i_rx_valid         (i_rx_valid),
        .i_rx_is_ack        (i_rx_is_ack),
        .i_rx_is_nak        (i_rx_is_nak),
        .i_rx_channel       (i_rx_channel),
        .i_rx_ack_seq       (i_rx_ack_seq),
        .i_retry_timeout_ms (r_retry_timeout_ms),
        .i_max_retries      (r_max_retries),
        .o_result_valid     (o_result_valid),
        .o_status           (o_status),
        .o_slot_index       (o_slot_index),
        .o_out_channel      (o_out_channel),
        .o_out_seq          (o_out_seq)
    );

endmodule
